[design/qgd_pkg.sv]
// Shared types, widths and constants of the density-block gate unit.
package qgd_pkg;

    localparam int FRAC_BITS = 30;
    localparam int COEF_W    = 32;
    localparam int OPND_W    = 35;
    localparam int PROD_W    = COEF_W + OPND_W;
    localparam int SUM_W     = PROD_W + 3;
    localparam int RND_W     = SUM_W - FRAC_BITS + 1;
    localparam int NUM_LANES = 8;
    localparam int NUM_TERMS = 3;
    localparam int CFG_W     = 31;
    localparam int IDX_W     = 2;

    localparam logic signed [COEF_W-1:0] ONE_Q      = 32'sd1073741824;
    localparam logic signed [COEF_W-1:0] HALF_Q     = 32'sd536870912;
    localparam logic signed [COEF_W-1:0] INV_SQRT2_Q = 32'sd759250125;

    localparam logic [3:0] OP_X   = 4'd0;
    localparam logic [3:0] OP_Y   = 4'd1;
    localparam logic [3:0] OP_Z   = 4'd2;
    localparam logic [3:0] OP_H   = 4'd3;
    localparam logic [3:0] OP_HY  = 4'd4;
    localparam logic [3:0] OP_S   = 4'd5;
    localparam logic [3:0] OP_SDG = 4'd6;
    localparam logic [3:0] OP_T   = 4'd7;
    localparam logic [3:0] OP_TDG = 4'd8;
    localparam logic [3:0] OP_P   = 4'd9;
    localparam logic [3:0] OP_RX  = 4'd10;
    localparam logic [3:0] OP_RY  = 4'd11;

    localparam logic [IDX_W-1:0] REG_COS_SQ  = 2'd0;
    localparam logic [IDX_W-1:0] REG_SIN_SQ  = 2'd1;
    localparam logic [IDX_W-1:0] REG_COS_SIN = 2'd2;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [OPND_W-1:0] opnd_t;

    typedef struct packed {
        coef_t [NUM_TERMS-1:0] coef;
        opnd_t [NUM_TERMS-1:0] opnd;
    } term_t;

    typedef struct packed {
        logic neg;
        logic zero;
    } lane_ctl_t;

endpackage

[design/qgd_in_if.sv]
// Input channel: one 2x2 block and the gate to apply.
interface qgd_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic        on_diag;
    logic        upper_01;
    logic [31:0] a00_re;
    logic [31:0] a00_im;
    logic [31:0] a01_re;
    logic [31:0] a01_im;
    logic [31:0] a10_re;
    logic [31:0] a10_im;
    logic [31:0] a11_re;
    logic [31:0] a11_im;

    modport source (output valid, opcode, on_diag, upper_01, a00_re, a00_im, a01_re,
                    a01_im, a10_re, a10_im, a11_re, a11_im, input ready);
    modport sink (input valid, opcode, on_diag, upper_01, a00_re, a00_im, a01_re,
                  a01_im, a10_re, a10_im, a11_re, a11_im, output ready);
endinterface

[design/qgd_out_if.sv]
// Output channel: the new 2x2 block and the write-back flag of element 01.
interface qgd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] b00_re;
    logic [31:0] b00_im;
    logic [31:0] b01_re;
    logic [31:0] b01_im;
    logic [31:0] b10_re;
    logic [31:0] b10_im;
    logic [31:0] b11_re;
    logic [31:0] b11_im;
    logic        write_01;

    modport source (output valid, b00_re, b00_im, b01_re, b01_im, b10_re, b10_im, b11_re,
                    b11_im, write_01, input ready);
    modport sink (input valid, b00_re, b00_im, b01_re, b01_im, b10_re, b10_im, b11_re,
                  b11_im, write_01, output ready);
endinterface

[design/qgd_select.sv]
// Gate decode: picks coefficient and operand of each term for all eight result lanes.
module qgd_select
    import qgd_pkg::*;
#(
    parameter int WORD_W = 32
)
(
    input  logic [3:0]            opcode,
    input  logic                  on_diag,
    input  logic                  upper_01,
    input  logic [31:0]           a00_re,
    input  logic [31:0]           a00_im,
    input  logic [31:0]           a01_re,
    input  logic [31:0]           a01_im,
    input  logic [31:0]           a10_re,
    input  logic [31:0]           a10_im,
    input  logic [31:0]           a11_re,
    input  logic [31:0]           a11_im,
    input  logic [CFG_W-1:0]      cos_sq,
    input  logic [CFG_W-1:0]      sin_sq,
    input  logic [CFG_W-1:0]      cos_sin,
    output term_t [NUM_LANES-1:0] terms
);

    function automatic opnd_t sx(input logic [31:0] v);
        sx = OPND_W'($signed(v[WORD_W-1:0]));
    endfunction

    opnd_t r00r, r00i, r01r, r01i, r10r, r10i, r11r, r11i, s01r, s01i;
    opnd_t sum_r, sum_i, hb_r, hb_i, hc_r, hc_i, hd_r, hd_i;
    opnd_t dx_r, dx_i, dy_r, dy_i, e_r, e_i;
    coef_t c2, s2, cs, cs_full, pc, ps;
    coef_t cf [NUM_LANES][NUM_TERMS];
    opnd_t op [NUM_LANES][NUM_TERMS];
    opnd_t own [NUM_LANES];

    assign r00r = sx(a00_re);
    assign r00i = sx(a00_im);
    assign s01r = sx(a01_re);
    assign s01i = sx(a01_im);
    assign r10r = sx(a10_re);
    assign r10i = sx(a10_im);
    assign r11r = sx(a11_re);
    assign r11i = sx(a11_im);

    // Element 01 in true form: mirror of 10 on the diagonal, unconjugate if stored upper
    assign r01r = on_diag ? r10r : s01r;
    assign r01i = on_diag ? -r10i : (upper_01 ? -s01i : s01i);

    // H and Hy sign patterns, halved through the HALF_Q coefficient
    assign sum_r = r00r + r01r + r10r + r11r;
    assign sum_i = r00i + r01i + r10i + r11i;
    assign hb_r  = r00r - r01r - r10r + r11r;
    assign hb_i  = r00i - r01i - r10i + r11i;
    assign hc_r  = r00r - r01r + r10r - r11r;
    assign hc_i  = r00i - r01i + r10i - r11i;
    assign hd_r  = r00r + r01r - r10r - r11r;
    assign hd_i  = r00i + r01i - r10i - r11i;
    assign dx_r  = r01r - r10r;
    assign dx_i  = r01i - r10i;
    assign dy_r  = r01r + r10r;
    assign dy_i  = r01i + r10i;
    assign e_r   = r00r - r11r;
    assign e_i   = r00i - r11i;

    assign c2      = (cos_sq > CFG_W'(ONE_Q)) ? ONE_Q : COEF_W'({1'b0, cos_sq});
    assign s2      = (sin_sq > CFG_W'(ONE_Q)) ? ONE_Q : COEF_W'({1'b0, sin_sq});
    assign cs_full = COEF_W'($signed(cos_sin));
    assign cs      = (cs_full > HALF_Q) ? HALF_Q : ((cs_full < -HALF_Q) ? -HALF_Q : cs_full);
    assign pc      = c2 - s2;
    assign ps      = cs <<< 1;

    assign own[0] = r00r;
    assign own[1] = r00i;
    assign own[2] = r01r;
    assign own[3] = r01i;
    assign own[4] = r10r;
    assign own[5] = r10i;
    assign own[6] = r11r;
    assign own[7] = r11i;

    always_comb
    begin
        for (int j = 0; j < NUM_LANES; j++)
        begin
            for (int t = 0; t < NUM_TERMS; t++)
            begin
                cf[j][t] = '0;
                op[j][t] = '0;
            end
            cf[j][0] = ONE_Q;
            op[j][0] = own[j];
        end
        case (opcode)
            OP_X:
            begin
                op[0][0] = r11r; op[1][0] = r11i; op[6][0] = r00r; op[7][0] = r00i;
                op[2][0] = r10r; op[3][0] = r10i; op[4][0] = r01r; op[5][0] = r01i;
            end
            OP_Y:
            begin
                op[0][0] = r11r; op[1][0] = r11i; op[6][0] = r00r; op[7][0] = r00i;
                op[2][0] = r10r; op[3][0] = r10i; op[4][0] = r01r; op[5][0] = r01i;
                for (int j = 2; j < 6; j++)
                begin
                    cf[j][0] = -ONE_Q;
                end
            end
            OP_Z:
            begin
                for (int j = 2; j < 6; j++)
                begin
                    cf[j][0] = -ONE_Q;
                end
            end
            OP_H:
            begin
                for (int j = 0; j < NUM_LANES; j++)
                begin
                    cf[j][0] = HALF_Q;
                end
                op[0][0] = sum_r; op[1][0] = sum_i; op[6][0] = hb_r; op[7][0] = hb_i;
                op[2][0] = hc_r;  op[3][0] = hc_i;  op[4][0] = hd_r; op[5][0] = hd_i;
            end
            OP_HY:
            begin
                for (int j = 0; j < NUM_LANES; j++)
                begin
                    cf[j][0] = HALF_Q;
                end
                op[0][0] = hb_r; op[1][0] = hb_i; op[6][0] = sum_r; op[7][0] = sum_i;
                op[2][0] = hd_r; op[3][0] = hd_i; op[4][0] = hc_r;  op[5][0] = hc_i;
            end
            OP_S:
            begin
                cf[4][0] = -ONE_Q; op[4][0] = r10i; op[5][0] = r10r;
                op[2][0] = r01i; cf[3][0] = -ONE_Q; op[3][0] = r01r;
            end
            OP_SDG:
            begin
                op[4][0] = r10i; cf[5][0] = -ONE_Q; op[5][0] = r10r;
                cf[2][0] = -ONE_Q; op[2][0] = r01i; op[3][0] = r01r;
            end
            OP_T, OP_TDG, OP_P:
            begin
                // Rotate 10 by (c + i s) and 01 by (c - i s)
                cf[4][0] = (opcode == OP_P) ? pc : INV_SQRT2_Q;
                cf[4][1] = (opcode == OP_P) ? -ps : ((opcode == OP_T) ? -INV_SQRT2_Q
                                                                      : INV_SQRT2_Q);
                cf[5][0] = cf[4][0];
                cf[5][1] = -cf[4][1];
                cf[2][0] = cf[4][0];
                cf[2][1] = -cf[4][1];
                cf[3][0] = cf[4][0];
                cf[3][1] = cf[4][1];
                op[4][0] = r10r; op[4][1] = r10i;
                op[5][0] = r10i; op[5][1] = r10r;
                op[2][0] = r01r; op[2][1] = r01i;
                op[3][0] = r01i; op[3][1] = r01r;
            end
            OP_RX:
            begin
                cf[0][0] = c2;  op[0][0] = r00r; cf[0][1] = s2; op[0][1] = r11r;
                cf[0][2] = -cs; op[0][2] = dx_i;
                cf[1][0] = c2;  op[1][0] = r00i; cf[1][1] = s2; op[1][1] = r11i;
                cf[1][2] = cs;  op[1][2] = dx_r;
                cf[6][0] = s2;  op[6][0] = r00r; cf[6][1] = c2; op[6][1] = r11r;
                cf[6][2] = cs;  op[6][2] = dx_i;
                cf[7][0] = s2;  op[7][0] = r00i; cf[7][1] = c2; op[7][1] = r11i;
                cf[7][2] = -cs; op[7][2] = dx_r;
                cf[2][0] = -cs; op[2][0] = e_i;  cf[2][1] = c2; op[2][1] = r01r;
                cf[2][2] = s2;  op[2][2] = r10r;
                cf[3][0] = cs;  op[3][0] = e_r;  cf[3][1] = c2; op[3][1] = r01i;
                cf[3][2] = s2;  op[3][2] = r10i;
                cf[4][0] = cs;  op[4][0] = e_i;  cf[4][1] = c2; op[4][1] = r10r;
                cf[4][2] = s2;  op[4][2] = r01r;
                cf[5][0] = -cs; op[5][0] = e_r;  cf[5][1] = c2; op[5][1] = r10i;
                cf[5][2] = s2;  op[5][2] = r01i;
            end
            OP_RY:
            begin
                cf[0][0] = c2;  op[0][0] = r00r; cf[0][1] = s2;  op[0][1] = r11r;
                cf[0][2] = -cs; op[0][2] = dy_r;
                cf[1][0] = c2;  op[1][0] = r00i; cf[1][1] = s2;  op[1][1] = r11i;
                cf[1][2] = -cs; op[1][2] = dy_i;
                cf[6][0] = s2;  op[6][0] = r00r; cf[6][1] = c2;  op[6][1] = r11r;
                cf[6][2] = cs;  op[6][2] = dy_r;
                cf[7][0] = s2;  op[7][0] = r00i; cf[7][1] = c2;  op[7][1] = r11i;
                cf[7][2] = cs;  op[7][2] = dy_i;
                cf[2][0] = cs;  op[2][0] = e_r;  cf[2][1] = c2;  op[2][1] = r01r;
                cf[2][2] = -s2; op[2][2] = r10r;
                cf[3][0] = cs;  op[3][0] = e_i;  cf[3][1] = c2;  op[3][1] = r01i;
                cf[3][2] = -s2; op[3][2] = r10i;
                cf[4][0] = cs;  op[4][0] = e_r;  cf[4][1] = c2;  op[4][1] = r10r;
                cf[4][2] = -s2; op[4][2] = r01r;
                cf[5][0] = cs;  op[5][0] = e_i;  cf[5][1] = c2;  op[5][1] = r10i;
                cf[5][2] = -s2; op[5][2] = r01i;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        for (int j = 0; j < NUM_LANES; j++)
        begin
            for (int t = 0; t < NUM_TERMS; t++)
            begin
                terms[j].coef[t] = cf[j][t];
                terms[j].opnd[t] = op[j][t];
            end
        end
    end

endmodule

[design/qgd_lane.sv]
// One result lane: three products, then sum, round half up, optional negate, saturate, optional zero.
module qgd_lane
    import qgd_pkg::*;
#(
    parameter int WORD_W = 32
)
(
    input  logic        clk,
    input  logic        en,
    input  term_t       term,
    input  lane_ctl_t   ctl,
    output logic [31:0] result
);

    localparam logic signed [RND_W-1:0] SAT_HI =
        RND_W'((64'sd1 <<< (WORD_W - 1)) - 64'sd1);
    localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);
    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

    logic signed [PROD_W-1:0] prod_reg [NUM_TERMS];
    logic signed [PROD_W-1:0] prod_next [NUM_TERMS];
    lane_ctl_t                ctl_reg;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sum_sh;
    logic signed [RND_W-1:0]  rnd_val;
    logic signed [RND_W-1:0]  sgn_val;
    logic signed [RND_W-1:0]  sat_val;
    logic [31:0]              result_reg;
    logic [31:0]              result_next;

    always_comb
    begin
        for (int t = 0; t < NUM_TERMS; t++)
        begin
            prod_next[t] = $signed(term.coef[t]) * $signed(term.opnd[t]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod_next;
            ctl_reg    <= ctl;
            result_reg <= result_next;
        end
    end

    assign sum     = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
                     + RND_HALF;
    assign sum_sh  = sum >>> FRAC_BITS;
    assign rnd_val = sum_sh[RND_W-1:0];
    // Conjugate after rounding, before saturation
    assign sgn_val = ctl_reg.neg ? -rnd_val : rnd_val;
    assign sat_val = (sgn_val > SAT_HI) ? SAT_HI : ((sgn_val < SAT_LO) ? SAT_LO : sgn_val);
    assign result_next = ctl_reg.zero ? 32'd0 : sat_val[31:0];
    assign result = result_reg;

endmodule

[design/qubit_gate_density_block_core.sv]
// Pipeline: an accepted item passes the input, product and result registers on its way to its result.
// Throughput: one item per cycle; the three stages advance together whenever the
// result register is empty or its item is being taken.
// Reset: clears stage valid bits; cos_sq resets to 1.0 (Q1.30), sin_sq and cos_sin to 0.
// Datapath registers hold no reset value.
module qubit_gate_density_block_core
    import qgd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    qgd_in_if.sink           in_ch,
    qgd_out_if.source        out_ch,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int WORD_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

    logic [CFG_W-1:0] cos_sq_reg, sin_sq_reg, cos_sin_reg;
    logic             en;
    logic             v0_reg, v1_reg, v2_reg;
    logic             wr1_reg, wr2_reg;
    logic [3:0]       opcode_reg;
    logic             diag_reg, upper_reg;
    logic [31:0]      a_reg [NUM_LANES];
    term_t [NUM_LANES-1:0] terms;
    lane_ctl_t        ctl [NUM_LANES];
    logic [31:0]      lane_res [NUM_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_sq_reg  <= CFG_W'(ONE_Q);
            sin_sq_reg  <= '0;
            cos_sin_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COS_SQ:  cos_sq_reg  <= cfg_data;
                REG_SIN_SQ:  sin_sq_reg  <= cfg_data;
                REG_COS_SIN: cos_sin_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Advance the whole pipeline unless a finished item is stalled at the output
    assign en = !v2_reg || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_ch.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            opcode_reg <= in_ch.opcode;
            diag_reg   <= in_ch.on_diag;
            upper_reg  <= in_ch.upper_01;
            a_reg[0]   <= in_ch.a00_re;
            a_reg[1]   <= in_ch.a00_im;
            a_reg[2]   <= in_ch.a01_re;
            a_reg[3]   <= in_ch.a01_im;
            a_reg[4]   <= in_ch.a10_re;
            a_reg[5]   <= in_ch.a10_im;
            a_reg[6]   <= in_ch.a11_re;
            a_reg[7]   <= in_ch.a11_im;
            wr1_reg    <= !diag_reg;
            wr2_reg    <= wr1_reg;
        end
    end

    qgd_select #(.WORD_W(WORD_W)) u_select (
        .opcode     (opcode_reg),
        .on_diag    (diag_reg),
        .upper_01   (upper_reg),
        .a00_re     (a_reg[0]),
        .a00_im     (a_reg[1]),
        .a01_re     (a_reg[2]),
        .a01_im     (a_reg[3]),
        .a10_re     (a_reg[4]),
        .a10_im     (a_reg[5]),
        .a11_re     (a_reg[6]),
        .a11_im     (a_reg[7]),
        .cos_sq     (cos_sq_reg),
        .sin_sq     (sin_sq_reg),
        .cos_sin    (cos_sin_reg),
        .terms      (terms)
    );

    always_comb
    begin
        for (int j = 0; j < NUM_LANES; j++)
        begin
            ctl[j] = '0;
        end
        // Element 01 is dropped on the diagonal and conjugated when stored upper
        ctl[2].zero = diag_reg;
        ctl[3].zero = diag_reg;
        ctl[3].neg  = upper_reg && !diag_reg;
    end

    for (genvar j = 0; j < NUM_LANES; j++)
    begin : g_lane
        qgd_lane #(.WORD_W(WORD_W)) u_lane (
            .clk    (clk),
            .en     (en),
            .term   (terms[j]),
            .ctl    (ctl[j]),
            .result (lane_res[j])
        );
    end

    assign out_ch.valid    = v2_reg;
    assign out_ch.b00_re   = lane_res[0];
    assign out_ch.b00_im   = lane_res[1];
    assign out_ch.b01_re   = lane_res[2];
    assign out_ch.b01_im   = lane_res[3];
    assign out_ch.b10_re   = lane_res[4];
    assign out_ch.b10_im   = lane_res[5];
    assign out_ch.b11_re   = lane_res[6];
    assign out_ch.b11_im   = lane_res[7];
    assign out_ch.write_01 = wr2_reg;

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> v0_reg)
        else $error("accepted item did not enter the input stage");

    a_diag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.write_01) |-> (out_ch.b01_re == 32'd0 &&
                                                out_ch.b01_im == 32'd0))
        else $error("element 01 not cleared on a diagonal block");

    a_pipe_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.ready && v1_reg) |=> v2_reg)
        else $error("item lost between product and result stages");
`endif

endmodule

[bench/qubit_gate_density_block_core_test.sv]
// Testbench of the density-block gate unit: directed table, then random blocks, self-checked.
`timescale 1ns / 100ps

module qubit_gate_density_block_core_test;
    import qgd_pkg::*;

    localparam int  STALL_LIMIT = 5000;
    localparam int  DRAIN_CYCLES = 6;
    localparam int  RANDOM_PER_SETTING = 170;
    localparam logic [31:0] W_MAX = 32'h7fffffff;
    localparam logic [31:0] W_MIN = 32'h80000000;

    typedef struct {
        logic [3:0]  op;
        logic        diag;
        logic        upper;
        logic [31:0] a[8];
        bit          typed;
        logic [31:0] b[8];
        logic        wr;
    } block_row_t;

    typedef struct {
        logic [31:0] b[8];
        logic        wr;
    } block_res_t;

    logic clk;
    logic rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    qgd_in_if  in_ch ();
    qgd_out_if out_ch ();

    qubit_gate_density_block_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies used by the predictor
    longint      gate_cos_sq;
    longint      gate_sin_sq;
    logic [30:0] gate_cos_sin;

    block_res_t  expected_blocks[$];
    block_row_t  directed_rows[$];
    int          mismatch_count;
    int          sender_idle_pct;
    int          recv_idle_pct;
    int          stall_cycles;
    string       field_names[8] = '{"b00_re", "b00_im", "b01_re", "b01_im",
                                    "b10_re", "b10_im", "b11_re", "b11_im"};

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint round_shift(longint acc, int k);
        return (acc + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic longint mix3(longint a, longint x, longint b, longint y,
                                    longint c, longint z);
        return round_shift(a * x + b * y + c * z, FRAC_BITS);
    endfunction

    function automatic longint half_sum(longint a, longint b, longint c, longint d);
        return round_shift(a + b + c + d, 1);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [31:0] sat_word(longint v);
        longint s;
        s = clamp(v, -64'sd2147483648, 64'sd2147483647);
        return s[31:0];
    endfunction

    function automatic block_res_t conjugate_block(block_row_t r);
        block_res_t res;
        longint x[8];
        longint n[8];
        longint pr, pi, c2, s2, cs, pc, ps, dr, di, er, ei, k;
        for (int i = 0; i < 8; i++)
            x[i] = longint'($signed(r.a[i]));
        // element 01 in its true form
        if (r.diag)
        begin
            pr = x[4];
            pi = -x[5];
        end
        else
        begin
            pr = x[2];
            pi = r.upper ? -x[3] : x[3];
        end
        c2 = clamp(gate_cos_sq, 0, 64'sd1073741824);
        s2 = clamp(gate_sin_sq, 0, 64'sd1073741824);
        cs = clamp(longint'($signed(gate_cos_sin)), -64'sd536870912, 64'sd536870912);
        pc = c2 - s2;
        ps = 2 * cs;
        k  = longint'(INV_SQRT2_Q);
        n = '{x[0], x[1], pr, pi, x[4], x[5], x[6], x[7]};
        case (r.op)
            OP_X:
            begin
                n = '{x[6], x[7], x[4], x[5], pr, pi, x[0], x[1]};
            end
            OP_Y:
            begin
                n = '{x[6], x[7], -x[4], -x[5], -pr, -pi, x[0], x[1]};
            end
            OP_Z:
            begin
                n[2] = -pr; n[3] = -pi; n[4] = -x[4]; n[5] = -x[5];
            end
            OP_H:
            begin
                n[0] = half_sum(x[0], pr, x[4], x[6]);
                n[1] = half_sum(x[1], pi, x[5], x[7]);
                n[6] = half_sum(x[0], -pr, -x[4], x[6]);
                n[7] = half_sum(x[1], -pi, -x[5], x[7]);
                n[2] = half_sum(x[0], -pr, x[4], -x[6]);
                n[3] = half_sum(x[1], -pi, x[5], -x[7]);
                n[4] = half_sum(x[0], pr, -x[4], -x[6]);
                n[5] = half_sum(x[1], pi, -x[5], -x[7]);
            end
            OP_HY:
            begin
                n[0] = half_sum(x[0], -pr, -x[4], x[6]);
                n[1] = half_sum(x[1], -pi, -x[5], x[7]);
                n[6] = half_sum(x[0], pr, x[4], x[6]);
                n[7] = half_sum(x[1], pi, x[5], x[7]);
                n[2] = half_sum(x[0], pr, -x[4], -x[6]);
                n[3] = half_sum(x[1], pi, -x[5], -x[7]);
                n[4] = half_sum(x[0], -pr, x[4], -x[6]);
                n[5] = half_sum(x[1], -pi, x[5], -x[7]);
            end
            OP_S:
            begin
                n[4] = -x[5]; n[5] = x[4]; n[2] = pi; n[3] = -pr;
            end
            OP_SDG:
            begin
                n[4] = x[5]; n[5] = -x[4]; n[2] = -pi; n[3] = pr;
            end
            OP_T, OP_TDG, OP_P:
            begin
                longint c, s;
                c = (r.op == OP_P) ? pc : k;
                s = (r.op == OP_P) ? ps : ((r.op == OP_T) ? k : -k);
                n[4] = mix3(x[4], c, -x[5], s, 0, 0);
                n[5] = mix3(x[5], c, x[4], s, 0, 0);
                n[2] = mix3(pr, c, -pi, -s, 0, 0);
                n[3] = mix3(pi, c, pr, -s, 0, 0);
            end
            OP_RX:
            begin
                dr = pr - x[4]; di = pi - x[5];
                er = x[0] - x[6]; ei = x[1] - x[7];
                n[0] = mix3(c2, x[0], s2, x[6], -cs, di);
                n[1] = mix3(c2, x[1], s2, x[7], cs, dr);
                n[6] = mix3(s2, x[0], c2, x[6], cs, di);
                n[7] = mix3(s2, x[1], c2, x[7], -cs, dr);
                n[2] = mix3(-cs, ei, c2, pr, s2, x[4]);
                n[3] = mix3(cs, er, c2, pi, s2, x[5]);
                n[4] = mix3(cs, ei, c2, x[4], s2, pr);
                n[5] = mix3(-cs, er, c2, x[5], s2, pi);
            end
            OP_RY:
            begin
                dr = pr + x[4]; di = pi + x[5];
                er = x[0] - x[6]; ei = x[1] - x[7];
                n[0] = mix3(c2, x[0], s2, x[6], -cs, dr);
                n[1] = mix3(c2, x[1], s2, x[7], -cs, di);
                n[6] = mix3(s2, x[0], c2, x[6], cs, dr);
                n[7] = mix3(s2, x[1], c2, x[7], cs, di);
                n[2] = mix3(cs, er, c2, pr, -s2, x[4]);
                n[3] = mix3(cs, ei, c2, pi, -s2, x[5]);
                n[4] = mix3(cs, er, c2, x[4], -s2, pr);
                n[5] = mix3(cs, ei, c2, x[5], -s2, pi);
            end
            default: ;
        endcase
        for (int i = 0; i < 8; i++)
            res.b[i] = sat_word(n[i]);
        if (r.diag)
        begin
            res.b[2] = '0;
            res.b[3] = '0;
        end
        else if (r.upper)
            res.b[3] = sat_word(-n[3]);
        res.wr = !r.diag;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // scoreboard: compare each taken result with the oldest expectation
    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
        begin
            block_res_t want;
            logic [31:0] got[8];
            got = '{out_ch.b00_re, out_ch.b00_im, out_ch.b01_re, out_ch.b01_im,
                    out_ch.b10_re, out_ch.b10_im, out_ch.b11_re, out_ch.b11_im};
            if (expected_blocks.size() == 0)
                report_mismatch("unexpected block", got[0], 'x);
            else
            begin
                want = expected_blocks.pop_front();
                for (int i = 0; i < 8; i++)
                    if (got[i] !== want.b[i])
                        report_mismatch(field_names[i], got[i], want.b[i]);
                if (out_ch.write_01 !== want.wr)
                    report_mismatch("write_01", {31'b0, out_ch.write_01}, {31'b0, want.wr});
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[qubit_gate_density_block_core] ERROR");
            $finish;
        end
    end

    task automatic send_block(block_row_t r);
        // stay idle with the sender's idle odds before driving the block
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= r.op;
        in_ch.on_diag    <= r.diag;
        in_ch.upper_01   <= r.upper;
        in_ch.a00_re <= r.a[0]; in_ch.a00_im <= r.a[1];
        in_ch.a01_re <= r.a[2]; in_ch.a01_im <= r.a[3];
        in_ch.a10_re <= r.a[4]; in_ch.a10_im <= r.a[5];
        in_ch.a11_re <= r.a[6]; in_ch.a11_im <= r.a[7];
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (r.typed)
            expected_blocks.push_back('{b: r.b, wr: r.wr});
        else
            expected_blocks.push_back(conjugate_block(r));
    endtask

    // hold off until every result is back, then let the pipe empty
    task automatic drain_blocks();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_blocks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_gate_regs(logic [30:0] c2, logic [30:0] s2, logic [30:0] cs);
        cfg_we <= 1'b1;
        cfg_index <= REG_COS_SQ;  cfg_data <= c2;
        @(posedge clk);
        cfg_index <= REG_SIN_SQ;  cfg_data <= s2;
        @(posedge clk);
        cfg_index <= REG_COS_SIN; cfg_data <= cs;
        @(posedge clk);
        cfg_we <= 1'b0;
        gate_cos_sq  = longint'(c2);
        gate_sin_sq  = longint'(s2);
        gate_cos_sin = cs;
        @(posedge clk);
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(3))
                    0:       return W_MAX;
                    1:       return W_MIN;
                    2:       return 32'h0;
                    default: return 32'hffffffff;
                endcase
            end
            1, 2, 3: return $urandom();
            default: return 32'($urandom_range(32'h8000_0000) - 32'h4000_0000);
        endcase
    endfunction

    function automatic block_row_t random_block();
        block_row_t r;
        r.op    = ($urandom_range(99) < 6) ? 4'($urandom_range(12, 15))
                                           : 4'($urandom_range(11));
        r.diag  = ($urandom_range(3) == 0);
        r.upper = $urandom_range(1);
        for (int i = 0; i < 8; i++)
            r.a[i] = random_word();
        r.typed = 1'b0;
        return r;
    endfunction

    function automatic block_row_t typed_row(logic [3:0] op, logic diag, logic upper,
                                             logic [31:0] a[8], logic [31:0] b[8],
                                             logic wr);
        block_row_t r;
        r.op = op; r.diag = diag; r.upper = upper;
        r.a = a; r.b = b; r.wr = wr; r.typed = 1'b1;
        return r;
    endfunction

    initial
    begin
        logic [30:0] settings[7][3];
        block_row_t  r;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_COS_SQ;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_X;
        in_ch.on_diag = 1'b0;
        in_ch.upper_01 = 1'b0;
        {in_ch.a00_re, in_ch.a00_im, in_ch.a01_re, in_ch.a01_im} = '0;
        {in_ch.a10_re, in_ch.a10_im, in_ch.a11_re, in_ch.a11_im} = '0;
        out_ch.ready = 1'b0;
        mismatch_count = 0;
        stall_cycles = 0;
        sender_idle_pct = 13;
        recv_idle_pct = 54;
        gate_cos_sq = 64'sd1073741824;
        gate_sin_sq = 0;
        gate_cos_sin = '0;

        // swap, sign flip with negation overflow, unknown gate, diagonal block
        directed_rows.push_back(typed_row(OP_X, 1'b0, 1'b0, '{1, 2, 3, 4, 5, 6, 7, 8},
                                          '{7, 8, 5, 6, 3, 4, 1, 2}, 1'b1));
        directed_rows.push_back(typed_row(OP_Z, 1'b0, 1'b0, '{1, 2, W_MIN, 4, 5, 6, 7, 8},
                                          '{1, 2, W_MAX, -4, -5, -6, 7, 8}, 1'b1));
        directed_rows.push_back(typed_row(4'd15, 1'b0, 1'b1, '{1, 2, 3, 4, 5, 6, 7, 8},
                                          '{1, 2, 3, 4, 5, 6, 7, 8}, 1'b1));
        directed_rows.push_back(typed_row(OP_Z, 1'b1, 1'b0, '{1, 2, 3, 4, 5, 6, 7, 8},
                                          '{1, 2, 0, 0, -5, -6, 7, 8}, 1'b0));
        for (int op = 0; op < 12; op++)
        begin
            r.op = 4'(op);
            r.diag = (op == 3 || op == 10);
            r.upper = op[0];
            if (op < 6)
                r.a = '{W_MAX, W_MIN, W_MIN, W_MAX, W_MAX, W_MIN, W_MIN, W_MAX};
            else
                r.a = '{W_MIN, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN, W_MAX, W_MAX};
            r.typed = 1'b0;
            directed_rows.push_back(r);
        end
        for (int i = 0; i < 4; i++)
        begin
            r = random_block();
            r.op = (i < 2) ? OP_RX : OP_RY;
            directed_rows.push_back(r);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_block(directed_rows[i]);
        drain_blocks();

        settings = '{'{31'h4000_0000, 31'h0,         31'h0},
                     '{31'h0,         31'h4000_0000, 31'h0},
                     '{31'h2000_0000, 31'h2000_0000, 31'h2000_0000},
                     '{31'h2000_0000, 31'h2000_0000, 31'h6000_0000},
                     '{31'h7fff_ffff, 31'h7fff_ffff, 31'h4000_0000},
                     '{31'h3b20_d79e, 31'h04df_2862, 31'h1b5c_1a84},
                     '{31'h0,         31'h0,         31'h3fff_ffff}};
        for (int s = 0; s < 7; s++)
        begin
            write_gate_regs(settings[s][0], settings[s][1], settings[s][2]);
            for (int n = 0; n < RANDOM_PER_SETTING; n++)
            begin
                if (n == RANDOM_PER_SETTING / 3)
                begin
                    sender_idle_pct = 54;
                    recv_idle_pct = 13;
                end
                else if (n == 2 * RANDOM_PER_SETTING / 3)
                begin
                    sender_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                send_block(random_block());
            end
            drain_blocks();
            sender_idle_pct = 13;
            recv_idle_pct = 54;
        end

        if (mismatch_count == 0)
            $display("[qubit_gate_density_block_core] OK");
        else
            $display("[qubit_gate_density_block_core] ERROR");
        $finish;
    end

endmodule
